// File: src/assert_macros.svh
// Assertion macros used by the matrix-vector multiply sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: src/mvm_pkg.sv
// Constants, types and control structures shared by the matrix-vector multiply.
package mvm_pkg;

  localparam int MAX_ROWS  = 16;
  localparam int MAX_COLS  = 16;
  localparam int FRAC_BITS = 16;

  localparam int FIELD_W = 5;
  localparam int VAL_W   = 32;
  localparam int ACC_W   = 64;

  localparam int RIDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);
  localparam int CCNT_W = $clog2(MAX_COLS + 1);

  localparam int RST_ROWS = (MAX_ROWS < 16) ? MAX_ROWS : 16;
  localparam int RST_COLS = (MAX_COLS < 16) ? MAX_COLS : 16;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

  localparam logic MODE_MATRIX = 1'b0;
  localparam logic MODE_VECTOR = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } state_t;

  // Vector element travelling down the row of cells.
  typedef struct packed {
    logic                    vld;
    logic [CIDX_W-1:0]       col;
    logic signed [VAL_W-1:0] val;
  } tok_t;

  // Controls from the sequencer to every cell.
  typedef struct packed {
    logic              wr_en;
    logic [RIDX_W-1:0] wr_row;
    logic [CIDX_W-1:0] wr_col;
    logic [VAL_W-1:0]  wr_data;
    tok_t              tok;
    logic              shift;
    logic              clear;
  } ctl_t;

endpackage

// File: src/mvm_cell.sv
// One row cell: a matrix row, its multiplier and its saturating accumulator.
module mvm_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mvm_pkg::ctl_t                     ctl,
  input  logic                              wr_sel,
  input  logic                              row_en,
  input  mvm_pkg::tok_t                     tok_in,
  output mvm_pkg::tok_t                     tok_out,
  input  logic signed [mvm_pkg::ACC_W-1:0]  acc_in,
  output logic signed [mvm_pkg::ACC_W-1:0]  acc_out
);
  import mvm_pkg::*;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  logic [VAL_W-1:0]        mrow_r [MAX_COLS];
  logic signed [VAL_W-1:0] elem;
  logic signed [ACC_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [ACC_W:0]   sum;
  logic                    add_r;
  tok_t                    tok_r;

  // Matrix row storage; written by broadcast, read at the passing column.
  always_ff @(posedge clk) begin
    if (wr_sel) begin
      mrow_r[ctl.wr_col] <= ctl.wr_data;
    end
  end

  assign elem     = $signed(mrow_r[tok_in.col]);
  assign prod_nxt = elem * tok_in.val;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      add_r     <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      add_r     <= tok_in.vld && row_en;
      tok_r.vld <= tok_in.vld;
    end
    tok_r.col <= tok_in.col;
    tok_r.val <= tok_in.val;
  end

  assign sum = {acc_r[ACC_W-1], acc_r} + {prod_r[ACC_W-1], prod_r};

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (ctl.shift) begin
      acc_nxt = acc_in;
    end else if (add_r) begin
      if (sum[ACC_W] != sum[ACC_W-1]) begin
        acc_nxt = sum[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
        acc_nxt = sum[ACC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign tok_out = tok_r;
  assign acc_out = acc_r;

endmodule

// File: src/mvm_ctrl.sv
// Sequencer: configuration registers, beat decode, run timing and result drain.
`include "assert_macros.svh"

module mvm_ctrl (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_mode,
  input  logic [mvm_pkg::FIELD_W-1:0]          in_row,
  input  logic [mvm_pkg::FIELD_W-1:0]          in_col,
  input  logic signed [mvm_pkg::VAL_W-1:0]     in_value,
  input  logic                                 in_last,
  input  logic                                 cfg_valid,
  input  logic [mvm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mvm_pkg::FIELD_W-1:0]          cfg_data,
  input  logic                                 out_space,
  output mvm_pkg::ctl_t                        ctl,
  output logic [mvm_pkg::RCNT_W-1:0]           nrows,
  output logic [mvm_pkg::FIELD_W-1:0]          emit_row,
  output logic                                 emit_last
);
  import mvm_pkg::*;

  state_t              state_r, state_nxt;
  logic [RCNT_W-1:0]   nrows_r;
  logic [CCNT_W-1:0]   ncols_r;
  logic [RCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                fin_r, fin_nxt;
  logic                wr_en_r, wr_en_nxt;
  logic [RIDX_W-1:0]   wr_row_r, wr_row_nxt;
  logic [CIDX_W-1:0]   wr_col_r, wr_col_nxt;
  logic [VAL_W-1:0]    wr_data_r, wr_data_nxt;
  tok_t                tok_r, tok_nxt;
  logic                accept, row_ok, col_ok, shift, clear;
  logic [FIELD_W-1:0]  row_m1, col_m1;

  function automatic logic [RCNT_W-1:0] eff_rows(input logic [FIELD_W-1:0] v);
    if (v == '0) return RCNT_W'(1);
    if (32'(v) > MAX_ROWS) return RCNT_W'(MAX_ROWS);
    return RCNT_W'(v);
  endfunction

  function automatic logic [CCNT_W-1:0] eff_cols(input logic [FIELD_W-1:0] v);
    if (v == '0) return CCNT_W'(1);
    if (32'(v) > MAX_COLS) return CCNT_W'(MAX_COLS);
    return CCNT_W'(v);
  endfunction

  // Register writes keep the clamped count, so the datapath never sees zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nrows_r <= RCNT_W'(RST_ROWS);
      ncols_r <= CCNT_W'(RST_COLS);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROWS: nrows_r <= eff_rows(cfg_data);
        REG_COLS: ncols_r <= eff_cols(cfg_data);
        default:  ;
      endcase
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign row_m1   = in_row - FIELD_W'(1);
  assign col_m1   = in_col - FIELD_W'(1);
  assign row_ok   = (in_row != '0) && (32'(in_row) <= 32'(nrows_r));
  assign col_ok   = (in_col != '0) && (32'(in_col) <= 32'(ncols_r));

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    fin_nxt     = fin_r;
    wr_en_nxt   = 1'b0;
    wr_row_nxt  = wr_row_r;
    wr_col_nxt  = wr_col_r;
    wr_data_nxt = wr_data_r;
    tok_nxt     = tok_r;
    tok_nxt.vld = 1'b0;
    shift       = 1'b0;
    clear       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_MATRIX) begin
            wr_en_nxt   = row_ok && col_ok;
            wr_row_nxt  = RIDX_W'(row_m1);
            wr_col_nxt  = CIDX_W'(col_m1);
            wr_data_nxt = in_value;
          end else begin
            tok_nxt.vld = col_ok;
            tok_nxt.col = CIDX_W'(col_m1);
            tok_nxt.val = in_value;
            fin_nxt     = in_last;
            cnt_nxt     = '0;
            state_nxt   = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        // The element walks down the cells to the last one, which registers its
        // product and then adds it to its accumulator.
        cnt_nxt = cnt_r + RCNT_W'(1);
        if (cnt_r == RCNT_W'(MAX_ROWS)) begin
          cnt_nxt   = '0;
          state_nxt = fin_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        shift = out_space;
        if (out_space) begin
          cnt_nxt = cnt_r + RCNT_W'(1);
          if (cnt_r == nrows_r - RCNT_W'(1)) begin
            clear     = 1'b1;
            cnt_nxt   = '0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      fin_r     <= 1'b0;
      wr_en_r   <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      fin_r     <= fin_nxt;
      wr_en_r   <= wr_en_nxt;
      tok_r.vld <= tok_nxt.vld;
    end
    wr_row_r  <= wr_row_nxt;
    wr_col_r  <= wr_col_nxt;
    wr_data_r <= wr_data_nxt;
    tok_r.col <= tok_nxt.col;
    tok_r.val <= tok_nxt.val;
  end

  assign ctl.wr_en   = wr_en_r;
  assign ctl.wr_row  = wr_row_r;
  assign ctl.wr_col  = wr_col_r;
  assign ctl.wr_data = wr_data_r;
  assign ctl.tok     = tok_r;
  assign ctl.shift   = shift;
  assign ctl.clear   = clear;

  assign nrows     = nrows_r;
  assign emit_row  = FIELD_W'(cnt_r) + FIELD_W'(1);
  assign emit_last = (cnt_r == nrows_r - RCNT_W'(1));

  `ASSERT_IMP(a_shift_in_emit, clk, rst_n, ctl.shift, state_r == ST_EMIT)
  `ASSERT_IMP(a_clear_on_last, clk, rst_n, ctl.clear, ctl.shift && emit_last)
  `ASSERT_NXT(a_vector_runs, clk, rst_n, accept && (in_mode == MODE_VECTOR), state_r == ST_RUN)
  `ASSERT_IMP(a_emit_in_range, clk, rst_n, state_r == ST_EMIT, cnt_r < nrows_r)

endmodule

// File: src/matrix_vector_multiply.sv
// Top level of the dense matrix-vector multiply: cell chain, sequencer, result register.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+--------------------------------------------
//  in_     | input     | in_tvalid/in_tready   | tdata row, col, value; tuser mode; tlast
//  out_    | output    | out_tvalid/out_tready | tdata result_row, product_value; tlast
//  cfg_    | input     | cfg_valid/cfg_ready   | cfg_index register, cfg_data value
//
// A matrix-write beat leaves the input ready for the next beat. A vector beat holds
// in_tready low while the element walks down the chain of row cells, one cell per cycle,
// and the last cell registers its product and then adds it. A vector beat with tlast set
// then drains one result per row in use, one per cycle while out_tready is high; the
// accumulators shift toward the output through the same chain and clear on the last one.
// Reset (rst_n low, synchronous) clears the control state and the accumulators; the
// matrix holds garbage until written and needs no clearing pass. The configuration port
// is always ready; out_tready low only stalls the drain, and the result register lets a
// new input beat be taken while the last result still waits.
module matrix_vector_multiply (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // in_tdata, low bit up: row_index[4:0], col_index[9:5], value[41:10], zero pad.
  input  logic [mvm_pkg::IN_TDATA_W-1:0]         in_tdata,
  // in_tuser: mode (0 matrix write, 1 vector element).
  input  logic                                   in_tuser,
  input  logic                                   in_tlast,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // out_tdata, low bit up: result_row[4:0], product_value[36:5], zero pad.
  output logic [mvm_pkg::OUT_TDATA_W-1:0]        out_tdata,
  output logic                                   out_tlast,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [mvm_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [mvm_pkg::FIELD_W-1:0]            cfg_data
);
  import mvm_pkg::*;

  localparam logic [ACC_W:0] HALF = (ACC_W + 1)'(2 ** FRAC_BITS) >> 1;
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam int PAD_W = OUT_TDATA_W - FIELD_W - VAL_W;

  ctl_t                    ctl;
  logic [RCNT_W-1:0]       nrows;
  logic [FIELD_W-1:0]      emit_row;
  logic                    emit_last;
  logic                    out_space;
  tok_t                    tok_w [MAX_ROWS+1];
  logic signed [ACC_W-1:0] acc_w [MAX_ROWS+1];

  logic                    out_vld_r;
  logic [FIELD_W-1:0]      out_row_r;
  logic signed [VAL_W-1:0] out_val_r;
  logic                    out_last_r;

  // Round to nearest with ties toward plus infinity, then saturate to 32 bits.
  function automatic logic signed [VAL_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W:0] s;
    logic signed [ACC_W:0] q;
    s = {a[ACC_W-1], a} + HALF;
    q = s >>> FRAC_BITS;
    if (q[ACC_W:VAL_W-1] == '0 || q[ACC_W:VAL_W-1] == '1) return q[VAL_W-1:0];
    return q[ACC_W] ? VAL_MIN : VAL_MAX;
  endfunction

  assign out_space = !out_vld_r || out_tready;
  assign cfg_ready = 1'b1;

  mvm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_mode   (in_tuser),
    .in_row    (in_tdata[4:0]),
    .in_col    (in_tdata[9:5]),
    .in_value  ($signed(in_tdata[41:10])),
    .in_last   (in_tlast),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_space (out_space),
    .ctl       (ctl),
    .nrows     (nrows),
    .emit_row  (emit_row),
    .emit_last (emit_last)
  );

  // The element enters at cell 0 and moves one cell per cycle; accumulators
  // move the other way during the drain, with zero entering at the far end.
  assign tok_w[0]        = ctl.tok;
  assign acc_w[MAX_ROWS] = '0;

  for (genvar i = 0; i < MAX_ROWS; i++) begin : g_cell
    mvm_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .wr_sel  (ctl.wr_en && (ctl.wr_row == RIDX_W'(i))),
      .row_en  (i < int'(nrows)),
      .tok_in  (tok_w[i]),
      .tok_out (tok_w[i+1]),
      .acc_in  (acc_w[i+1]),
      .acc_out (acc_w[i])
    );
  end

  // Result register: loads the head of the chain on each drain step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (ctl.shift) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
    if (ctl.shift) begin
      out_row_r  <= emit_row;
      out_val_r  <= round_sat(acc_w[0]);
      out_last_r <= emit_last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_val_r, out_row_r};

endmodule

// File: sim/tb_matrix_vector_multiply.sv
// Self-checking testbench for the matrix-vector multiply, with a row-product predictor.
module tb_matrix_vector_multiply;
  import mvm_pkg::*;

  // The longest quiet stretch is the deliberate result hold-off. Otherwise a beat
  // waits at most a sender gap, a receiver stall and one vector pass.
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned STALL_LIMIT   = 3000;
  localparam int unsigned SETTLE_CYCLES = MAX_ROWS + 8;
  localparam int unsigned MAX_GAP       = 12;
  localparam int unsigned RANDOM_BEATS  = 310;
  localparam int unsigned PAD_W         = IN_TDATA_W - 2 * FIELD_W - VAL_W;

  // Indexes that decode to no register.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam logic signed [VAL_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] Q_ONE = 32'sh0001_0000;

  typedef struct packed {
    logic [FIELD_W-1:0]      row;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } row_result_t;

  logic                   clk;
  logic                   rst_n;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   in_tlast;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [FIELD_W-1:0]     cfg_data;

  // Predictor copy of the matrix, the row sums and the size registers.
  logic signed [VAL_W-1:0] coef [MAX_ROWS][MAX_COLS];
  bit                      coef_known [MAX_ROWS][MAX_COLS];
  longint                  row_sum [MAX_ROWS];
  logic [FIELD_W-1:0]      rows_reg;
  logic [FIELD_W-1:0]      cols_reg;
  row_result_t             row_results_due [$];

  int unsigned mismatches  = 0;
  int unsigned beats_sent  = 0;
  int unsigned idle_cycles = 0;
  bit          gaps_on     = 1'b1;
  bit          hold_req    = 1'b0;

  matrix_vector_multiply i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // A size register of zero counts as one, anything above the maximum as the maximum.
  function automatic int unsigned in_use(logic [FIELD_W-1:0] raw, int unsigned limit);
    if (raw == 0) return 1;
    if (raw > limit) return limit;
    return 32'(raw);
  endfunction

  function automatic longint add_clamped(longint a, longint b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64:63] == 2'b01) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s[64:63] == 2'b10) return 64'sh8000_0000_0000_0000;
    return s[63:0];
  endfunction

  // Q32.32 to Q16.16: round half up, then clamp to 32 bits.
  function automatic logic signed [VAL_W-1:0] round_to_q16(longint a);
    longint q;
    q = a >>> FRAC_BITS;
    if (a[FRAC_BITS-1:0] >= (1 << (FRAC_BITS - 1))) q = q + 1;
    if (q > longint'(Q_MAX)) return Q_MAX;
    if (q < longint'(Q_MIN)) return Q_MIN;
    return q[VAL_W-1:0];
  endfunction

  function automatic void accumulate_beat(logic mode, logic [FIELD_W-1:0] row,
                                          logic [FIELD_W-1:0] col,
                                          logic signed [VAL_W-1:0] val, logic last);
    int unsigned nr;
    int unsigned nc;
    int          r;
    row_result_t res;
    nr = in_use(rows_reg, MAX_ROWS);
    nc = in_use(cols_reg, MAX_COLS);
    if (mode == MODE_MATRIX) begin
      if (row >= 1 && row <= nr && col >= 1 && col <= nc) begin
        coef[row-1][col-1]       = val;
        coef_known[row-1][col-1] = 1'b1;
      end
      return;
    end
    if (col >= 1 && col <= nc) begin
      for (r = 0; r < nr; r++)
        row_sum[r] = add_clamped(row_sum[r], longint'(coef[r][col-1]) * longint'(val));
    end
    if (last) begin
      for (r = 0; r < nr; r++) begin
        res.row   = FIELD_W'(r + 1);
        res.value = round_to_q16(row_sum[r]);
        res.last  = (r + 1 == nr);
        row_results_due.push_back(res);
      end
      for (r = 0; r < MAX_ROWS; r++) row_sum[r] = 0;
    end
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2, 3:    return $urandom_range(0, 32'h3FFFF) - 32'h20000;
      default: return $urandom();
    endcase
  endfunction

  // Mostly small sizes; zero, one, the maximum and values past it now and then.
  function automatic logic [FIELD_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return FIELD_W'(0);
      1:       return FIELD_W'(1);
      2:       return FIELD_W'(MAX_ROWS);
      3:       return FIELD_W'($urandom_range(17, 31));
      default: return FIELD_W'($urandom_range(2, 5));
    endcase
  endfunction

  // Sends one beat; in_tvalid stays high on return so back-to-back beats need no toggle.
  task automatic send_beat(logic mode, logic [FIELD_W-1:0] row, logic [FIELD_W-1:0] col,
                           logic signed [VAL_W-1:0] val, logic last);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {{PAD_W{1'b0}}, val, col, row};
    in_tuser  <= mode;
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    accumulate_beat(mode, row, col, val, last);
    beats_sent++;
  endtask

  task automatic put_coef(int row, int col, logic signed [VAL_W-1:0] val, logic last = 1'b0);
    send_beat(MODE_MATRIX, FIELD_W'(row), FIELD_W'(col), val, last);
  endtask

  // The row field of a vector beat is don't-care, so it carries random bits.
  task automatic put_elem(int col, logic signed [VAL_W-1:0] val, logic last);
    send_beat(MODE_VECTOR, FIELD_W'($urandom_range(0, 31)), FIELD_W'(col), val, last);
  endtask

  // Writes any entry of a column that a vector beat would read before it was written.
  task automatic ensure_column(int col);
    int unsigned nr;
    int          r;
    nr = in_use(rows_reg, MAX_ROWS);
    for (r = 0; r < nr; r++)
      if (!coef_known[r][col-1]) put_coef(r + 1, col, pick_value());
  endtask

  // Waits for every predicted result, then for the last silent beat to finish.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (row_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_ROWS) rows_reg = data;
    else if (idx == REG_COLS) cols_reg = data;
    @(posedge clk);
  endtask

  task automatic configure(logic [FIELD_W-1:0] rows, logic [FIELD_W-1:0] cols);
    wait_drained();
    write_reg(REG_ROWS, rows);
    write_reg(REG_COLS, cols);
  endtask

  // Zero sizes act as one; unknown indexes change nothing; writes outside the
  // array are dropped.
  task automatic test_register_limits();
    configure(0, 0);
    write_reg(REG_SPARE_A, 5'h1F);
    write_reg(REG_SPARE_B, 5'h00);
    put_coef(1, 1, Q_ONE);
    put_coef(2, 1, Q_MAX);
    put_coef(1, 2, Q_MAX);
    put_coef(0, 1, Q_MIN);
    put_coef(1, 0, Q_MIN);
    put_elem(1, 32'sh0003_0000, 1'b1);
  endtask

  task automatic test_rounding_and_saturation();
    configure(2, 2);
    put_coef(1, 1, Q_MIN);
    put_coef(2, 1, 32'sd1);
    put_coef(1, 2, Q_MIN);
    // A final flag on a matrix write must not start a drain.
    put_coef(2, 2, Q_MAX, 1'b1);
    // Row one climbs past the top of the accumulator, row two clamps at the output.
    put_elem(1, Q_MIN, 1'b0);
    put_elem(2, Q_MIN, 1'b1);
    // Exact half-way remainders, positive and negative.
    put_elem(1, 32'sh0000_8000, 1'b1);
    put_elem(1, -32'sh0000_8000, 1'b1);
    // Row one falls past the bottom of the accumulator.
    put_elem(1, Q_MAX, 1'b0);
    put_elem(2, Q_MAX, 1'b0);
    put_elem(1, Q_MAX, 1'b1);
    // Columns outside the matrix add nothing but still honor the final flag.
    put_elem(0, Q_MAX, 1'b1);
    put_elem(3, Q_MAX, 1'b0);
    put_elem(31, Q_MIN, 1'b1);
  endtask

  // All sixteen rows, with the first and last columns and one past the end.
  task automatic test_full_size();
    configure(31, FIELD_W'(MAX_COLS));
    ensure_column(1);
    ensure_column(MAX_COLS);
    put_elem(1, pick_value(), 1'b0);
    put_elem(MAX_COLS, Q_MAX, 1'b0);
    put_elem(MAX_COLS + 1, Q_MIN, 1'b0);
    put_elem(MAX_COLS, pick_value(), 1'b1);
  endtask

  // The receiver holds off while the sender keeps offering products back to back.
  task automatic test_result_stall();
    gaps_on = 1'b0;
    configure(4, 2);
    ensure_column(1);
    ensure_column(2);
    hold_req = 1'b1;
    repeat (3) begin
      put_elem(1, pick_value(), 1'b0);
      put_elem(2, pick_value(), 1'b1);
    end
    wait_drained();
    gaps_on = 1'b1;
  endtask

  task automatic run_product();
    int unsigned nr;
    int unsigned nc;
    int unsigned len;
    int unsigned col;
    int unsigned k;
    nr = in_use(rows_reg, MAX_ROWS);
    nc = in_use(cols_reg, MAX_COLS);
    repeat ($urandom_range(0, 3))
      put_coef($urandom_range(1, nr), $urandom_range(1, nc), pick_value(),
               1'($urandom_range(0, 1)));
    if ($urandom_range(0, 4) == 0)
      put_coef($urandom_range(0, 31), $urandom_range(0, 31), pick_value(),
               1'($urandom_range(0, 1)));
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, nc) : nc;
    for (k = 1; k <= len; k++) begin
      col = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : k;
      if (col >= 1 && col <= nc) ensure_column(col);
      put_elem(col, pick_value(), k == len);
    end
  endtask

  task automatic test_random_products();
    int unsigned stop_at;
    stop_at = beats_sent + RANDOM_BEATS;
    while (beats_sent < stop_at) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      configure(pick_size(), pick_size());
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                  FIELD_W'($urandom_range(0, 31)));
      repeat ($urandom_range(1, 4)) run_product();
    end
  endtask

  initial begin : stimulus
    int r;
    rst_n     <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= MODE_MATRIX;
    in_tlast  <= 1'b0;
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_ROWS;
    cfg_data  <= '0;
    rows_reg = FIELD_W'(RST_ROWS);
    cols_reg = FIELD_W'(RST_COLS);
    for (r = 0; r < MAX_ROWS; r++) row_sum[r] = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_limits();
    test_rounding_and_saturation();
    test_full_size();
    test_result_stall();
    test_random_products();
    wait_drained();
    if (mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  // Result side: a random stall before each beat, plus one long hold-off on request.
  initial begin : result_sink
    int unsigned stall;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready) && !hold_req);
    end
  end

  always @(posedge clk) begin : result_check
    row_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (row_results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result beat: row %0d value %h last %0b",
                   out_tdata[FIELD_W-1:0], out_tdata[FIELD_W+VAL_W-1:FIELD_W], out_tlast);
      end else begin
        want = row_results_due.pop_front();
        if (out_tdata[FIELD_W-1:0] !== want.row ||
            out_tdata[FIELD_W+VAL_W-1:FIELD_W] !== want.value ||
            out_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result mismatch: expected row %0d value %h last %0b, got row %0d value %h last %0b",
                     want.row, want.value, want.last, out_tdata[FIELD_W-1:0],
                     out_tdata[FIELD_W+VAL_W-1:FIELD_W], out_tlast);
        end
      end
    end
  end

  // Ends a hung run: too many cycles in a row without any accepted beat.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
